@@ design/bss_pkg.sv @@
// Shared constants, codes and helpers for the bucketed sequence store.
`default_nettype none
package bss_pkg;
  localparam int MAX_BUCKETS = 16;
  localparam int BUCKET_CAP  = 16;
  localparam int WORD_BITS   = 32;
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int IDX_W       = $clog2(BUCKET_CAP);
  localparam int ADDR_W      = BKT_W + IDX_W;
  localparam int SLOTS       = MAX_BUCKETS * BUCKET_CAP;

  localparam logic [2:0] FN_READ   = 3'd0;
  localparam logic [2:0] FN_INSERT = 3'd1;
  localparam logic [2:0] FN_DELETE = 3'd2;
  localparam logic [2:0] FN_PUSH   = 3'd3;
  localparam logic [2:0] FN_POP    = 3'd4;
  localparam logic [2:0] FN_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic [4:0] FILL_RESET = 5'd16;

  function automatic logic [4:0] clamp_fill(input logic [4:0] v);
    logic [4:0] f;
    f = v;
    if (f == 5'd0) f = 5'd1;
    if (f > 5'd16) f = 5'd16;
    return f;
  endfunction
endpackage
`default_nettype wire

@@ design/bss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/bucketed_sequence_store.sv @@
// Top level of the bucketed sequence store: sequencer, bucket tables and slot RAM.
//
//  channel  dir  handshake            payload
//  in       in   in_valid / in_stall  func, position, word_in
//  out      out  out_valid/ out_stall word_out, status, length
//  cfg      in   cfg_valid/ cfg_ready cfg_data (bucket fill)
//
// One request at a time. Locating a position walks the live buckets, one per cycle
// (up to 16). Shifting words inside a bucket reads and then writes each word through
// the single slot RAM port pair.
// Reset is synchronous; it empties the store and sets the fill to 16. No clearing pass.
// A held result does not block acceptance; the next result waits for the output register.
`default_nettype none
module bucketed_sequence_store (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [7:0]  position,
  input  wire logic [31:0] word_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      word_out,
  output logic [1:0]       status,
  output logic [8:0]       length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_DISPATCH = 19'h00002,
    S_LOCATE   = 19'h00004,
    S_REMOVE   = 19'h00008,
    S_SHL_RD   = 19'h00010,
    S_SHL_WR   = 19'h00020,
    S_PUSH     = 19'h00040,
    S_PUSH_WR  = 19'h00080,
    S_INS_CHK  = 19'h00100,
    S_SPILL    = 19'h00200,
    S_SHR_RD   = 19'h00400,
    S_SHR_WR   = 19'h00800,
    S_MOVE_RD  = 19'h01000,
    S_MOVE_WR  = 19'h02000,
    S_INS_SET  = 19'h04000,
    S_INS_WR   = 19'h08000,
    S_RD_ISSUE = 19'h10000,
    S_RD_DATA  = 19'h20000,
    S_FIN      = 19'h40000
  } state_t;

  state_t      state;
  logic [2:0]  op;
  logic [7:0]  pos_r;
  logic [31:0] word_r;
  logic [4:0]  fill_cfg;
  logic [4:0]  fill_r;
  logic [8:0]  rem;
  logic [4:0]  l;
  logic [3:0]  lb, off, p, q, sb, lo, idx;
  logic        spill;
  logic [4:0]  cnt [bss_pkg::MAX_BUCKETS];
  logic [3:0]  order [bss_pkg::MAX_BUCKETS];
  logic [15:0] free_map;
  logic [4:0]  live;
  logic [8:0]  total;
  logic [31:0] rd;
  logic [1:0]  st_r;

  logic [4:0]  last_l, lb1, c_cur, cp, cq, last_cnt, last_cm1, cp_m1;
  logic [3:0]  lastp, nq, cur, ff;
  logic        any_free;

  logic                        ram_we;
  logic [bss_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [31:0]                 ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign last_l   = live - 5'd1;
  assign lastp    = order[last_l[3:0]];
  assign last_cnt = cnt[lastp];
  assign last_cm1 = last_cnt - 5'd1;
  assign lb1      = {1'b0, lb} + 5'd1;
  assign nq       = order[lb1[3:0]];
  assign cur      = order[l[3:0]];
  assign c_cur    = cnt[cur];
  assign cp       = cnt[p];
  assign cq       = cnt[q];
  assign cp_m1    = cp - 5'd1;
  assign any_free = |free_map;

  // lowest free bucket
  always_comb begin
    ff = '0;
    for (int i = bss_pkg::MAX_BUCKETS - 1; i >= 0; i--) begin
      if (free_map[i]) ff = 4'(i);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state)
      S_SHL_RD:   ram_raddr = {p, idx + 4'd1};
      S_SHR_RD:   ram_raddr = {sb, idx - 4'd1};
      S_MOVE_RD:  ram_raddr = {p, cp_m1[3:0]};
      S_RD_ISSUE: ram_raddr = {p, off};
      S_SHL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {p, idx};
      end
      S_SHR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {sb, idx};
      end
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {q, 4'd0};
      end
      S_PUSH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {p, cp[3:0]};
        ram_wdata = word_r;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {p, off};
        ram_wdata = word_r;
      end
      default: ;
    endcase
  end

  bss_ram #(.WIDTH(bss_pkg::WORD_BITS), .DEPTH(bss_pkg::SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fill_cfg  <= bss_pkg::FILL_RESET;
      free_map  <= '1;
      live      <= '0;
      total     <= '0;
      for (int i = 0; i < bss_pkg::MAX_BUCKETS; i++) cnt[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) fill_cfg <= cfg_data;
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= func;
            pos_r  <= position;
            word_r <= word_in;
            fill_r <= bss_pkg::clamp_fill(fill_cfg);
            rd     <= '0;
            st_r   <= bss_pkg::ST_OK;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          l   <= '0;
          rem <= {1'b0, pos_r};
          case (op)
            bss_pkg::FN_READ, bss_pkg::FN_DELETE: state <= S_LOCATE;
            bss_pkg::FN_INSERT: begin
              if ({1'b0, pos_r} == total) state <= S_PUSH;
              else if ({1'b0, pos_r} > total) begin
                st_r  <= bss_pkg::ST_RANGE;
                state <= S_FIN;
              end else state <= S_LOCATE;
            end
            bss_pkg::FN_PUSH: state <= S_PUSH;
            bss_pkg::FN_POP: begin
              if (live == 5'd0) begin
                st_r  <= bss_pkg::ST_EMPTY;
                state <= S_FIN;
              end else begin
                lb    <= last_l[3:0];
                p     <= lastp;
                off   <= last_cm1[3:0];
                state <= S_REMOVE;
              end
            end
            bss_pkg::FN_CLEAR: begin
              free_map <= '1;
              live     <= '0;
              total    <= '0;
              for (int i = 0; i < bss_pkg::MAX_BUCKETS; i++) cnt[i] <= '0;
              state <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_LOCATE: begin
          if (l == live) begin
            st_r  <= bss_pkg::ST_RANGE;
            state <= S_FIN;
          end else if (rem < {4'd0, c_cur}) begin
            lb  <= l[3:0];
            off <= rem[3:0];
            p   <= cur;
            case (op)
              bss_pkg::FN_READ:   state <= S_RD_ISSUE;
              bss_pkg::FN_DELETE: state <= S_REMOVE;
              default:            state <= S_INS_CHK;
            endcase
          end else begin
            rem <= rem - {4'd0, c_cur};
            l   <= l + 5'd1;
          end
        end
        S_REMOVE: begin
          if (cp <= 5'd1) begin
            // last word gone: release bucket and close the gap in the order
            free_map[p] <= 1'b1;
            cnt[p]      <= '0;
            for (int i = 0; i < bss_pkg::MAX_BUCKETS - 1; i++) begin
              if (i >= lb) order[i] <= order[i + 1];
            end
            live  <= live - 5'd1;
            total <= total - 9'd1;
            state <= S_FIN;
          end else if ({1'b0, off} + 5'd1 < cp) begin
            idx   <= off;
            state <= S_SHL_RD;
          end else begin
            cnt[p] <= cp_m1;
            total  <= total - 9'd1;
            state  <= S_FIN;
          end
        end
        S_SHL_RD: state <= S_SHL_WR;
        S_SHL_WR: begin
          idx <= idx + 4'd1;
          if ({1'b0, idx} + 5'd2 < cp) state <= S_SHL_RD;
          else begin
            cnt[p] <= cp_m1;
            total  <= total - 9'd1;
            state  <= S_FIN;
          end
        end
        S_PUSH: begin
          if (live == 5'd0 || last_cnt >= fill_r) begin
            if (!any_free) begin
              st_r  <= bss_pkg::ST_NOROOM;
              state <= S_FIN;
            end else begin
              order[live[3:0]] <= ff;
              free_map[ff]     <= 1'b0;
              cnt[ff]          <= '0;
              live             <= live + 5'd1;
              p                <= ff;
              state            <= S_PUSH_WR;
            end
          end else begin
            p     <= lastp;
            state <= S_PUSH_WR;
          end
        end
        S_PUSH_WR: begin
          cnt[p] <= cp + 5'd1;
          total  <= total + 9'd1;
          state  <= S_FIN;
        end
        S_INS_CHK: begin
          if (cp >= fill_r) begin
            if (lb1 < live && cnt[nq] < fill_r) begin
              q     <= nq;
              state <= S_SPILL;
            end else if (!any_free) begin
              st_r  <= bss_pkg::ST_NOROOM;
              state <= S_FIN;
            end else begin
              // open a fresh bucket right after the full one
              for (int i = 1; i < bss_pkg::MAX_BUCKETS; i++) begin
                if (i > lb1) order[i] <= order[i - 1];
              end
              order[lb1[3:0]] <= ff;
              free_map[ff]    <= 1'b0;
              cnt[ff]         <= '0;
              live            <= live + 5'd1;
              q               <= ff;
              state           <= S_SPILL;
            end
          end else state <= S_INS_SET;
        end
        S_SPILL: begin
          sb    <= q;
          lo    <= '0;
          spill <= 1'b1;
          idx   <= cq[3:0];
          state <= (cq != 5'd0) ? S_SHR_RD : S_MOVE_RD;
        end
        S_SHR_RD: state <= S_SHR_WR;
        S_SHR_WR: begin
          idx <= idx - 4'd1;
          if (idx - 4'd1 > lo) state <= S_SHR_RD;
          else state <= spill ? S_MOVE_RD : S_INS_WR;
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: begin
          cnt[q] <= cq + 5'd1;
          cnt[p] <= cp_m1;
          state  <= S_INS_SET;
        end
        S_INS_SET: begin
          sb    <= p;
          lo    <= off;
          spill <= 1'b0;
          idx   <= cp[3:0];
          state <= (cp > {1'b0, off}) ? S_SHR_RD : S_INS_WR;
        end
        S_INS_WR: begin
          cnt[p] <= cp + 5'd1;
          total  <= total + 9'd1;
          state  <= S_FIN;
        end
        S_RD_ISSUE: state <= S_RD_DATA;
        S_RD_DATA: begin
          rd    <= ram_rdata;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            word_out  <= rd;
            status    <= st_r;
            length    <= total;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/bss_check.sv @@
// Port-level checks for the bucketed sequence store, bound to the top level.
`default_nettype none
module bss_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] word_out,
  input wire logic [1:0]  status,
  input wire logic [8:0]  length
);
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word_out) && $stable(status)
      && $stable(length))
    else $error("result changed while stalled");

  // errors never carry a word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bss_pkg::ST_OK |-> word_out == 32'd0)
    else $error("error result with nonzero word");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length <= 9'd256)
    else $error("length beyond capacity");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken while busy");
endmodule

bind bucketed_sequence_store bss_check u_bss_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .word_out  (word_out),
  .status    (status),
  .length    (length)
);
`default_nettype wire
